### rtl/frpf_pkg.sv
// ----------------------------------------------------------------------------
// frpf_pkg: shared types and constants of the pair finder
// Holds the item structs and the configuration register indexes.
// ----------------------------------------------------------------------------
package frpf_pkg;

  localparam int CoordW = 32;
  localparam int IdxW   = 6;

  localparam logic [1:0] CfgRadius      = 2'd0;
  localparam logic [1:0] CfgWindowStart = 2'd1;
  localparam logic [1:0] CfgWindowEnd   = 2'd2;

  localparam logic [30:0] RadiusReset      = 31'd1311;
  localparam logic [31:0] WindowStartReset = 32'd0;
  localparam logic [31:0] WindowEndReset   = 32'd3932160;

  typedef struct packed {
    logic signed [CoordW-1:0] pos_x;
    logic signed [CoordW-1:0] pos_y;
    logic signed [CoordW-1:0] pos_z;
    logic signed [CoordW-1:0] stamp;
    logic                     new_set;
  } point_t;

  typedef struct packed {
    logic [IdxW-1:0] first_index;
    logic [IdxW-1:0] second_index;
    logic            is_pair;
    logic            overflow;
    logic            last;
  } pair_t;

  // Job handed from the front part to the search engine.
  typedef struct packed {
    logic signed [CoordW-1:0] pos_x;
    logic signed [CoordW-1:0] pos_y;
    logic signed [CoordW-1:0] pos_z;
    logic                     in_win;
    logic                     dropped;
    logic                     overflow;
    logic [IdxW-1:0]          idx;
  } job_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_TERM
  } scan_state_t;

endpackage

### rtl/frpf_if.sv
// ----------------------------------------------------------------------------
// frpf_if: valid/ready channel
// Carries one payload of a parameter type between source and sink.
// ----------------------------------------------------------------------------
interface frpf_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/frpf_front.sv
// ----------------------------------------------------------------------------
// frpf_front: point classifier
// Assigns indexes, checks the time window and tracks overflow; pushes jobs.
// ----------------------------------------------------------------------------
module frpf_front #(
  parameter int MaxPoints = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  frpf_pkg::point_t       in_pt,
  input  logic signed [31:0]     win_start,
  input  logic signed [31:0]     win_end,
  output logic                   job_valid,
  input  logic                   job_ready,
  output frpf_pkg::job_t         job
);
  localparam int CntW = $clog2(MaxPoints + 1);

  logic [CntW-1:0] count_r, count_nxt;
  logic            ovf_r, ovf_nxt;
  logic [CntW-1:0] base;
  logic            ovf_base;
  logic            full;
  logic            fire;

  assign in_ready  = job_ready;
  assign job_valid = in_valid;
  assign fire      = in_valid && job_ready;

  always_comb begin
    base     = in_pt.new_set ? '0 : count_r;
    ovf_base = in_pt.new_set ? 1'b0 : ovf_r;
    full     = (base == CntW'(MaxPoints));
    count_nxt = full ? base : base + 1'b1;
    ovf_nxt   = ovf_base | full;
    job.pos_x    = in_pt.pos_x;
    job.pos_y    = in_pt.pos_y;
    job.pos_z    = in_pt.pos_z;
    job.in_win   = (in_pt.stamp >= win_start) && (in_pt.stamp <= win_end);
    job.dropped  = full;
    job.overflow = ovf_nxt;
    job.idx      = full ? '0 : frpf_pkg::IdxW'(base);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else if (fire) begin
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
    end
  end
endmodule

### rtl/frpf_fifo.sv
// ----------------------------------------------------------------------------
// frpf_fifo: two-entry job queue
// Decouples the classifier from the search engine.
// ----------------------------------------------------------------------------
module frpf_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  frpf_pkg::job_t wr_data,
  output logic           rd_valid,
  input  logic           rd_ready,
  output frpf_pkg::job_t rd_data
);
  frpf_pkg::job_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

### rtl/frpf_engine.sv
// ----------------------------------------------------------------------------
// frpf_engine: pair search engine
// Scans the point store one entry a cycle, while its output queue is empty,
// through a three-stage distance pipeline and emits pair and terminator items.
// ----------------------------------------------------------------------------
module frpf_engine #(
  parameter int MaxPoints = 64
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           job_valid,
  output logic           job_ready,
  input  frpf_pkg::job_t job,
  input  logic [30:0]    radius,
  output logic           out_valid,
  input  logic           out_ready,
  output frpf_pkg::pair_t out_item
);
  localparam int AW = (MaxPoints > 1) ? $clog2(MaxPoints) : 1;
  localparam int QD = 4;

  typedef logic [96:0] entry_t;

  entry_t mem [MaxPoints];

  frpf_pkg::scan_state_t state_r, state_nxt;
  frpf_pkg::job_t        cur_r;
  logic [AW:0]           ptr_r;
  logic [61:0]           r2_r;

  // Stage 1: read data valid; stage 2: squares; stage 3: compare.
  logic                  s1_v_r, s2_v_r, s3_v_r;
  logic [AW-1:0]         s1_i_r, s2_i_r, s3_i_r;
  entry_t                rd_r;
  logic [63:0]           sq_r [3];
  logic                  s2_w_r, s3_hit_r;
  logic [64:0]           sum_a;
  logic [65:0]           sum_b;
  logic [32:0]           dif [3];
  logic [32:0]           mag [3];

  // Output queue.
  frpf_pkg::pair_t       q_r [QD];
  logic [1:0]            qw_r, qr_r;
  logic [2:0]            qc_r;
  logic                  q_push, q_pop;
  frpf_pkg::pair_t       q_in;
  logic                  issue, pipe_busy, q_room;

  assign q_room    = (qc_r <= 3'(QD - 4));
  assign pipe_busy = s1_v_r || s2_v_r || s3_v_r;
  assign issue     = (state_r == frpf_pkg::ST_SCAN) &&
                     (ptr_r < {1'b0, cur_r.idx}) && q_room;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      frpf_pkg::ST_IDLE:  if (job_valid) state_nxt = frpf_pkg::ST_SCAN;
      frpf_pkg::ST_SCAN:  if (!(ptr_r < {1'b0, cur_r.idx}) || !cur_r.in_win || cur_r.dropped)
                            state_nxt = frpf_pkg::ST_DRAIN;
      frpf_pkg::ST_DRAIN: if (!pipe_busy) state_nxt = frpf_pkg::ST_TERM;
      frpf_pkg::ST_TERM:  if (qc_r < 3'(QD)) state_nxt = frpf_pkg::ST_IDLE;
      default:            state_nxt = frpf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    job_ready = (state_r == frpf_pkg::ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= frpf_pkg::ST_IDLE;
      ptr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == frpf_pkg::ST_IDLE) ptr_r <= '0;
      else if (issue && cur_r.in_win && !cur_r.dropped) ptr_r <= ptr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (job_valid && job_ready) begin
      cur_r <= job;
      r2_r  <= radius * radius;
    end
  end

  // Store write happens when the terminator is produced, after all reads.
  always_ff @(posedge clk) begin
    if (state_r == frpf_pkg::ST_TERM && state_nxt == frpf_pkg::ST_IDLE && !cur_r.dropped)
      mem[cur_r.idx[AW-1:0]] <= {cur_r.in_win, cur_r.pos_x, cur_r.pos_y, cur_r.pos_z};
    if (issue && cur_r.in_win && !cur_r.dropped)
      rd_r <= mem[ptr_r[AW-1:0]];
  end

  always_comb begin
    dif[0] = {cur_r.pos_x[31], cur_r.pos_x} - {rd_r[95], rd_r[95:64]};
    dif[1] = {cur_r.pos_y[31], cur_r.pos_y} - {rd_r[63], rd_r[63:32]};
    dif[2] = {cur_r.pos_z[31], cur_r.pos_z} - {rd_r[31], rd_r[31:0]};
    for (int k = 0; k < 3; k++) mag[k] = dif[k][32] ? -dif[k] : dif[k];
    sum_a = {1'b0, sq_r[0]} + {1'b0, sq_r[1]};
    sum_b = {1'b0, sum_a} + {2'b0, sq_r[2]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      s1_v_r <= issue && cur_r.in_win && !cur_r.dropped;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_i_r <= ptr_r[AW-1:0];
    s2_i_r <= s1_i_r;
    s3_i_r <= s2_i_r;
    s2_w_r <= rd_r[96];
    for (int k = 0; k < 3; k++) sq_r[k] <= mag[k][31:0] * mag[k][31:0];
    s3_hit_r <= s2_w_r && (sum_b <= {4'b0, r2_r});
  end

  always_comb begin
    q_in  = '0;
    q_push = 1'b0;
    if (s3_v_r && s3_hit_r) begin
      q_push          = 1'b1;
      q_in.first_index  = frpf_pkg::IdxW'(s3_i_r);
      q_in.second_index = cur_r.idx;
      q_in.is_pair      = 1'b1;
      q_in.overflow     = cur_r.overflow;
    end else if (state_r == frpf_pkg::ST_TERM && qc_r < 3'(QD)) begin
      q_push            = 1'b1;
      q_in.second_index = cur_r.idx;
      q_in.overflow     = cur_r.overflow;
      q_in.last         = 1'b1;
    end
  end

  assign out_valid = (qc_r != 3'd0);
  assign out_item  = q_r[qr_r];
  assign q_pop     = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (q_push) q_r[qw_r] <= q_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qw_r <= '0;
      qr_r <= '0;
      qc_r <= '0;
    end else begin
      if (q_push) qw_r <= qw_r + 1'b1;
      if (q_pop)  qr_r <= qr_r + 1'b1;
      qc_r <= qc_r + {2'b0, q_push} - {2'b0, q_pop};
    end
  end
endmodule

### rtl/fixed_radius_pair_finder.sv
// ----------------------------------------------------------------------------
// fixed_radius_pair_finder: fixed-radius near-neighbor pair search
// Finds, for each in-window point, all stored earlier in-window points within the radius.
// ----------------------------------------------------------------------------
// Channel | Direction | Payload
// in      | sink      | pos_x, pos_y, pos_z, stamp, new_set
// out     | source    | first_index, second_index, is_pair, overflow, last
// cfg     | write     | radius, window_start, window_end
//
// For an in-window request the engine reads one stored point per cycle into
// a three-stage distance pipeline. It only issues while the result queue is
// empty, so when stored points match, the scan slows down. Out-of-window and
// dropped requests skip the scan and go straight to their terminator.
// Reset is synchronous and clears counts, flags, queues and state, but not
// the point store. A two-entry job queue and a four-entry result queue let a
// stalled output pause the scan without losing items.
module fixed_radius_pair_finder #(
  parameter int MAX_POINTS = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  frpf_if.sink       in_ch,
  frpf_if.source     out_ch,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [31:0] cfg_data
);
  logic [30:0]        radius_r;
  logic signed [31:0] win_start_r, win_end_r;

  // Configuration registers; the user must write them only while the block is idle (not enforced here).
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r    <= frpf_pkg::RadiusReset;
      win_start_r <= frpf_pkg::WindowStartReset;
      win_end_r   <= frpf_pkg::WindowEndReset;
    end else if (cfg_we) begin
      case (cfg_index)
        frpf_pkg::CfgRadius:      radius_r    <= cfg_data[30:0];
        frpf_pkg::CfgWindowStart: win_start_r <= cfg_data;
        frpf_pkg::CfgWindowEnd:   win_end_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  logic           f_valid, f_ready, e_valid, e_ready;
  frpf_pkg::job_t f_job, e_job;

  // The classifier indexes each request and decides window and overflow.
  frpf_front #(.MaxPoints(MAX_POINTS)) u_front (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_pt(in_ch.data),
    .win_start(win_start_r), .win_end(win_end_r),
    .job_valid(f_valid), .job_ready(f_ready), .job(f_job)
  );

  frpf_fifo u_fifo (
    .clk, .rst_n,
    .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_job),
    .rd_valid(e_valid), .rd_ready(e_ready), .rd_data(e_job)
  );

  // The engine scans earlier points in ascending index order.
  frpf_engine #(.MaxPoints(MAX_POINTS)) u_engine (
    .clk, .rst_n,
    .job_valid(e_valid), .job_ready(e_ready), .job(e_job),
    .radius(radius_r),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_item(out_ch.data)
  );

  // A terminator always closes the item sequence of a request.
  a_term_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.data.last == !out_ch.data.is_pair))
    else $error("last flag disagrees with is_pair");

  // Pair items always name an earlier point.
  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.data.is_pair) |->
      (out_ch.data.first_index < out_ch.data.second_index))
    else $error("pair index order broken");

  // A pair item names index zero as the newer point only if the older one is zero too.
  a_term_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.data.is_pair) |-> (out_ch.data.first_index == 6'd0 ||
      out_ch.data.second_index != 6'd0))
    else $error("pair on index zero");
endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for fixed_radius_pair_finder
// Streams point requests through the block under several radius and window
// settings, predicts every pair and terminator item in a scoreboard, and
// compares each accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxPoints  = 64;
  localparam int CycleLimit = 2000000;
  localparam int DrainWait  = 100;

  // The scoreboard keeps its own copy of the point store and the registers
  // and turns every accepted point into the result items it must produce.
  class pair_scoreboard;
    logic signed [31:0] px [MaxPoints];
    logic signed [31:0] py [MaxPoints];
    logic signed [31:0] pz [MaxPoints];
    logic               pw [MaxPoints];
    int                 count;
    logic               ovf;
    logic [30:0]        radius;
    logic signed [31:0] win_lo;
    logic signed [31:0] win_hi;
    frpf_pkg::pair_t    pending_pairs [$];
    int                 mismatches;
    int                 results_seen;
    int                 pairs_seen;

    function new();
      count = 0;
      ovf = 1'b0;
      radius = frpf_pkg::RadiusReset;
      win_lo = frpf_pkg::WindowStartReset;
      win_hi = frpf_pkg::WindowEndReset;
      mismatches = 0;
      results_seen = 0;
      pairs_seen = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        frpf_pkg::CfgRadius:      radius = val[30:0];
        frpf_pkg::CfgWindowStart: win_lo = val;
        frpf_pkg::CfgWindowEnd:   win_hi = val;
        default: ;
      endcase
    endfunction

    function logic [63:0] axis_sq(logic signed [31:0] a, logic signed [31:0] b);
      logic signed [32:0] d;
      logic [32:0] m;
      d = a - b;
      m = d[32] ? -d : d;
      return 64'(m) * 64'(m);
    endfunction

    function void add_expected(int first, int second, logic is_pair, logic last);
      frpf_pkg::pair_t r;
      r.first_index = first[frpf_pkg::IdxW-1:0];
      r.second_index = second[frpf_pkg::IdxW-1:0];
      r.is_pair = is_pair;
      r.overflow = ovf;
      r.last = last;
      pending_pairs = {pending_pairs, r};
    endfunction

    function void note_point(frpf_pkg::point_t p);
      logic inw;
      logic [63:0] r2;
      logic [65:0] d2_sum;
      if (p.new_set) begin
        count = 0;
        ovf = 1'b0;
      end
      if (count >= MaxPoints) begin
        ovf = 1'b1;
        add_expected(0, 0, 1'b0, 1'b1);
        return;
      end
      inw = (p.stamp >= win_lo) && (p.stamp <= win_hi);
      r2 = 64'(radius) * 64'(radius);
      if (inw) begin
        for (int i = 0; i < count; i++) begin
          if (pw[i]) begin
            // A 66-bit sum cannot wrap, just like the 66-bit sum in the engine.
            d2_sum = 66'(axis_sq(p.pos_x, px[i])) + 66'(axis_sq(p.pos_y, py[i]))
                   + 66'(axis_sq(p.pos_z, pz[i]));
            if (d2_sum <= 66'(r2)) add_expected(i, count, 1'b1, 1'b0);
          end
        end
      end
      px[count] = p.pos_x;
      py[count] = p.pos_y;
      pz[count] = p.pos_z;
      pw[count] = inw;
      add_expected(0, count, 1'b0, 1'b1);
      count++;
    endfunction

    function void check_result(frpf_pkg::pair_t got);
      frpf_pkg::pair_t want;
      results_seen++;
      if (got.is_pair) pairs_seen++;
      if (pending_pairs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result item: first %0d second %0d pair %b ovf %b last %b",
                   got.first_index, got.second_index, got.is_pair, got.overflow, got.last);
        return;
      end
      want = pending_pairs.pop_front();
      if (got.first_index !== want.first_index || got.second_index !== want.second_index
          || got.is_pair !== want.is_pair || got.overflow !== want.overflow
          || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"result mismatch: expected first %0d second %0d pair %b ovf %b ",
                    "last %b, got first %0d second %0d pair %b ovf %b last %b"},
                   want.first_index, want.second_index, want.is_pair, want.overflow,
                   want.last, got.first_index, got.second_index, got.is_pair,
                   got.overflow, got.last);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  frpf_if #(.T(frpf_pkg::point_t)) in_if ();
  frpf_if #(.T(frpf_pkg::pair_t))  out_if ();

  fixed_radius_pair_finder #(.MAX_POINTS(MaxPoints)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if.sink),
    .out_ch    (out_if.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pair_scoreboard sb = new();

  // When quiet is set, neither side idles; the last part of the run uses it.
  bit quiet;
  // A request for one long stretch during which the receiver holds off.
  bit long_hold_req;
  int cycles;
  int points_sent;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = frpf_pkg::CfgRadius;
    cfg_data = '0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
  end

  // Cycle counter with a generous limit; a hung block ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Both monitors sample at the clock edge, before the bench's own updates.
  always @(posedge clk) begin
    if (rst_n && in_if.valid && in_if.ready) sb.note_point(in_if.data);
    if (rst_n && out_if.valid && out_if.ready) sb.check_result(out_if.data);
  end

  // The receiver stalls in random bursts, and once for a long stretch so that
  // the internal queues fill up and the block stops taking requests.
  initial begin
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_if.ready <= 1'b0;
        repeat (400) @(posedge clk);
        out_if.ready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Offers one request and waits for its handshake. Valid is lowered only
  // when a gap follows, so back-to-back requests keep it high.
  task automatic send_point(frpf_pkg::point_t p);
    in_if.valid <= 1'b1;
    in_if.data <= p;
    do @(posedge clk); while (!in_if.ready);
    points_sent++;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  // Registers are only written while the block is idle: the caller has
  // drained all results, and the extra wait covers any work still in flight.
  task automatic write_window(logic [30:0] r, logic [31:0] lo, logic [31:0] hi);
    in_if.valid <= 1'b0;
    repeat (DrainWait) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= frpf_pkg::CfgRadius;
    cfg_data <= {1'b0, r};
    sb.set_reg(frpf_pkg::CfgRadius, {1'b0, r});
    @(posedge clk);
    cfg_index <= frpf_pkg::CfgWindowStart;
    cfg_data <= lo;
    sb.set_reg(frpf_pkg::CfgWindowStart, lo);
    @(posedge clk);
    cfg_index <= frpf_pkg::CfgWindowEnd;
    cfg_data <= hi;
    sb.set_reg(frpf_pkg::CfgWindowEnd, hi);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain_results();
    while (sb.pending_pairs.size() != 0) @(posedge clk);
  endtask

  function automatic frpf_pkg::point_t make_point(logic signed [31:0] x,
                                                  logic signed [31:0] y,
                                                  logic signed [31:0] z,
                                                  logic signed [31:0] t,
                                                  logic ns);
    frpf_pkg::point_t p;
    p.pos_x = x;
    p.pos_y = y;
    p.pos_z = z;
    p.stamp = t;
    p.new_set = ns;
    return p;
  endfunction

  // Random point: mostly clustered near a center so that pairs form, with a
  // stamp mostly inside the window; the rest is full-range noise.
  logic signed [31:0] center_x, center_y, center_z;

  function automatic logic signed [31:0] near(logic signed [31:0] c, int span);
    return c + $signed(32'($urandom_range(0, 2 * span))) - span;
  endfunction

  function automatic frpf_pkg::point_t random_point(bit allow_new_set);
    frpf_pkg::point_t p;
    int span;
    longint lo, hi;
    span = (sb.radius > 31'd100000000) ? 200000000 : int'(sb.radius) + 2;
    lo = sb.win_lo;
    hi = sb.win_hi;
    if ($urandom_range(0, 99) < 15) begin
      p = make_point($urandom, $urandom, $urandom, $urandom, 1'b0);
    end else begin
      p.pos_x = near(center_x, span);
      p.pos_y = near(center_y, span);
      p.pos_z = near(center_z, span);
      if (lo <= hi && $urandom_range(0, 9) != 0)
        p.stamp = 32'(lo + longint'({$urandom, $urandom} % 64'(hi - lo + 1)));
      else
        p.stamp = $urandom;
    end
    p.new_set = allow_new_set && ($urandom_range(0, 24) == 0);
    return p;
  endfunction

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 15) == 0) begin
        center_x = $urandom;
        center_y = $urandom;
        center_z = $urandom;
      end
      send_point(random_point(1'b1));
    end
    in_if.valid <= 1'b0;
    drain_results();
  endtask

  initial begin
    quiet = 1'b0;
    long_hold_req = 1'b0;
    cycles = 0;
    points_sent = 0;
    center_x = 0;
    center_y = 0;
    center_z = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part under the reset settings: a distance exactly on the
    // radius matches, one step past it does not, and both window edges count.
    send_point(make_point(0, 0, 0, 0, 1'b1));
    send_point(make_point(100, 0, 0, 100, 1'b0));
    send_point(make_point(1311, 0, 0, 3932160, 1'b0));
    send_point(make_point(1312, 0, 0, 65536, 1'b0));
    send_point(make_point(0, 1311, 0, 3932161, 1'b0));
    send_point(make_point(0, 0, -1311, -1, 1'b0));
    send_point(make_point(0, 0, -1311, 0, 1'b0));
    send_point(make_point(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 1'b0));
    send_point(make_point(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h80000000, 1'b0));
    in_if.valid <= 1'b0;
    drain_results();

    // Largest radius with a full window: opposite corners give the largest sum.
    write_window(31'h7fffffff, 32'h80000000, 32'h7fffffff);
    send_point(make_point(32'h80000000, 32'h80000000, 32'h80000000, 0, 1'b1));
    send_point(make_point(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, 1'b0));
    send_point(make_point(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h80000000, 1'b0));
    send_point(make_point(32'h7fffffff, 0, 0, 32'h7fffffff, 1'b0));
    send_point(make_point(0, 0, 32'h80000000, 5, 1'b0));
    send_point(make_point(32'hffffffff, 0, 0, 5, 1'b0));
    in_if.valid <= 1'b0;
    drain_results();

    // Inverted window: nothing is in the window, so no pairs at all.
    write_window(31'd5000, 32'd100, 32'd99);
    send_point(make_point(0, 0, 0, 99, 1'b1));
    send_point(make_point(1, 0, 0, 100, 1'b0));
    send_point(make_point(2, 0, 0, 99, 1'b0));
    in_if.valid <= 1'b0;
    drain_results();

    // Zero radius: only coincident points pair.
    write_window(31'd0, 32'h80000000, 32'h7fffffff);
    send_point(make_point(7, 7, 7, 0, 1'b1));
    send_point(make_point(7, 7, 7, 1, 1'b0));
    send_point(make_point(7, 7, 8, 2, 1'b0));
    in_if.valid <= 1'b0;
    drain_results();

    // Fill the store past capacity; the dropped points set the sticky flag,
    // and a new set clears it again.
    write_window(31'd300000000, 32'h80000000, 32'h7fffffff);
    send_point(make_point($urandom, $urandom, $urandom, $urandom, 1'b1));
    for (int i = 0; i < MaxPoints + 2; i++)
      send_point(make_point($urandom, $urandom, $urandom, $urandom, 1'b0));
    send_point(make_point(0, 0, 0, 0, 1'b1));
    in_if.valid <= 1'b0;
    drain_results();

    // Random phases with varied settings. In the second one the receiver
    // holds off for a long stretch while the sender keeps offering requests.
    write_window(31'd1311, 32'd0, 32'd3932160);
    random_phase(20);
    write_window(31'd70000, 32'hfff00000, 32'd5000000);
    long_hold_req = 1'b1;
    random_phase(15);
    write_window(31'd20000000, 32'h80000000, 32'h7fffffff);
    random_phase(13);
    quiet = 1'b1;
    write_window(31'd200000, 32'h80000000, 32'd1000000);
    random_phase(13);

    repeat (DrainWait) @(posedge clk);
    $display("Sent %0d point requests under several radius and window settings.",
             points_sent);
    $display("Checked %0d result items, %0d of them pairs, %0d mismatches.",
             sb.results_seen, sb.pairs_seen, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_pairs.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### sim.f
rtl/frpf_pkg.sv
rtl/frpf_if.sv
rtl/frpf_front.sv
rtl/frpf_fifo.sv
rtl/frpf_engine.sv
rtl/fixed_radius_pair_finder.sv
tb/tb_top.sv
